@@ design/lmfs_pkg.sv @@
// ----------------------------------------------------------------------------
// lmfs_pkg
// Shared types and constants for the LED matrix frame store and scan unit.
// ----------------------------------------------------------------------------
package lmfs_pkg;

	localparam int unsigned NUM_COLS  = 16;
	localparam int unsigned NUM_ROWS  = 8;
	localparam int unsigned PIX_W     = 2;
	localparam int unsigned COL_W     = $clog2(NUM_COLS);
	localparam int unsigned ROW_W     = $clog2(NUM_ROWS);
	localparam int unsigned COLUMN_W  = NUM_ROWS * PIX_W;
	localparam int unsigned BEATS     = 64;
	localparam int unsigned CNT_W     = $clog2(BEATS);
	localparam int unsigned REQ_W     = 3;

	// request codes
	typedef enum logic [REQ_W-1:0] {
		REQ_WRITE   = 3'd0,
		REQ_FILL    = 3'd1,
		REQ_LEFT    = 3'd2,
		REQ_RIGHT   = 3'd3,
		REQ_UP      = 3'd4,
		REQ_REFRESH = 3'd5
	} req_code_t;

	// controller states
	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_SCAN = 1'b1
	} ctl_state_t;

	// input item
	typedef struct packed {
		logic [REQ_W-1:0] req_type;
		logic [COL_W-1:0] column;
		logic [ROW_W-1:0] row;
		logic [PIX_W-1:0] color;
		logic             wrap;
	} frame_req_t;

	// one shift beat
	typedef struct packed {
		logic red_top;
		logic green_top;
		logic red_bottom;
		logic green_bottom;
		logic latch_after;
	} scan_beat_t;

	// controller -> datapath
	typedef struct packed {
		logic      apply;     // perform a frame update this cycle
		req_code_t op;
		logic      cnt_load;  // start a refresh scan
		logic      beat_en;   // emit one beat and count down
	} ctl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic cnt_zero;
	} dp_status_t;

endpackage

@@ design/lmfs_ctrl.sv @@
// ----------------------------------------------------------------------------
// lmfs_ctrl
// Request decode and refresh sequencing state machine.
// ----------------------------------------------------------------------------
module lmfs_ctrl
	import lmfs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  frame_req_t req,
	input  dp_status_t status,
	output ctl_cmd_t   cmd,
	output logic       busy
);

	ctl_state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d      = state_q;
		cmd.apply    = 1'b0;
		cmd.op       = req_code_t'(req.req_type);
		cmd.cnt_load = 1'b0;
		cmd.beat_en  = 1'b0;
		busy         = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (req_code_t'(req.req_type) == REQ_REFRESH) begin
						cmd.cnt_load = 1'b1;
						state_d      = ST_SCAN;
					end else begin
						cmd.apply = 1'b1;
					end
				end
			end
			ST_SCAN: begin
				busy        = 1'b1;
				cmd.beat_en = 1'b1;
				if (status.cnt_zero) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

@@ design/lmfs_datapath.sv @@
// ----------------------------------------------------------------------------
// lmfs_datapath
// Column-organized frame registers with write/fill/scroll, beat counter and
// registered beat output.
// ----------------------------------------------------------------------------
module lmfs_datapath
	import lmfs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  frame_req_t req,
	input  ctl_cmd_t   cmd,
	output dp_status_t status,
	output scan_beat_t beat,
	output logic       strobe
);

	// each entry holds one column, row y at bits [2y+1:2y]
	logic [COLUMN_W-1:0] col_q [NUM_COLS];
	logic [CNT_W-1:0]    cnt_q;
	scan_beat_t          beat_q;
	logic                strobe_q;

	logic [COL_W-1:0]    rd_col;
	logic [1:0]          rd_h;
	logic [COLUMN_W-1:0] rd_data;
	logic [PIX_W-1:0]    top_pix;
	logic [PIX_W-1:0]    bot_pix;

	// frame updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int x = 0; x < NUM_COLS; x++) begin
				col_q[x] <= '0;
			end
		end else if (cmd.apply) begin
			case (cmd.op)
				REQ_WRITE: begin
					col_q[req.column][req.row*PIX_W +: PIX_W] <= req.color;
				end
				REQ_FILL: begin
					for (int x = 0; x < NUM_COLS; x++) begin
						col_q[x] <= {NUM_ROWS{req.color}};
					end
				end
				REQ_LEFT: begin
					for (int x = 0; x < NUM_COLS - 1; x++) begin
						col_q[x] <= col_q[x+1];
					end
					col_q[NUM_COLS-1] <= req.wrap ? col_q[0] : '0;
				end
				REQ_RIGHT: begin
					for (int x = 1; x < NUM_COLS; x++) begin
						col_q[x] <= col_q[x-1];
					end
					col_q[0] <= req.wrap ? col_q[NUM_COLS-1] : '0;
				end
				REQ_UP: begin
					// row 0 drops out or rotates into row 7
					for (int x = 0; x < NUM_COLS; x++) begin
						col_q[x] <= {(req.wrap ? col_q[x][PIX_W-1:0] : {PIX_W{1'b0}}),
							col_q[x][COLUMN_W-1:PIX_W]};
					end
				end
				default: begin
				end
			endcase
		end
	end

	// beat counter: bits [5:4] block-1, [3:2] row h, [1:0] column in block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.cnt_load) begin
			cnt_q <= CNT_W'(BEATS - 1);
		end else if (cmd.beat_en) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	assign status.cnt_zero = (cnt_q == '0);

	// column read and row pick
	assign rd_col  = {cnt_q[5:4], cnt_q[1:0]};
	assign rd_h    = cnt_q[3:2];
	assign rd_data = col_q[rd_col];
	assign top_pix = rd_data[{1'b0, rd_h}*PIX_W +: PIX_W];
	assign bot_pix = rd_data[{1'b1, rd_h}*PIX_W +: PIX_W];

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.beat_en;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.beat_en) begin
			beat_q.red_top      <= top_pix[0];
			beat_q.green_top    <= top_pix[1];
			beat_q.red_bottom   <= bot_pix[0];
			beat_q.green_bottom <= bot_pix[1];
			beat_q.latch_after  <= status.cnt_zero;
		end
	end

	assign beat   = beat_q;
	assign strobe = strobe_q;

endmodule

@@ design/led_matrix_frame_scroll_scan_unit.sv @@
// ----------------------------------------------------------------------------
// led_matrix_frame_scroll_scan_unit
// Bicolor 16x8 LED frame store with pixel write, fill, scrolls and a
// 64-beat shift refresh.
// ----------------------------------------------------------------------------
// Write, fill and scroll requests complete in the accept cycle; busy stays low.
// Refresh: busy while the scan runs, one beat per cycle read from the
// column registers; each beat is registered before it strobes, last beat has
// latch_after set. No new request is taken until the scan is over.
// Beats cannot be stalled. Reset clears the frame to black and returns idle.
module led_matrix_frame_scroll_scan_unit
	import lmfs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  frame_req_t req,
	output scan_beat_t beat,
	output logic       strobe
);

	ctl_cmd_t   cmd;
	dp_status_t status;

	lmfs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	lmfs_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.status (status),
		.beat   (beat),
		.strobe (strobe)
	);

endmodule

@@ verif/led_matrix_frame_scroll_scan_unit_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// led_matrix_frame_scroll_scan_unit_test
// Self-checking bench for the 16x8 bicolor frame store and its shift refresh.
// A short table of directed requests comes first. It covers fills in every
// color, corner pixels, all scrolls with and without wrap, and the unused
// request codes. Then a few hundred random requests follow, with random gaps
// between them. A local frame image, or the one color of a flat row, predicts the 64 beats of every refresh.
// Each strobed beat is compared with the oldest predicted beat.
// ----------------------------------------------------------------------------
module led_matrix_frame_scroll_scan_unit_test;
	import lmfs_pkg::*;

	localparam int unsigned CLK_HALF    = 5;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned DIR_ROWS    = 25;
	localparam int unsigned RAND_ITEMS  = 385;
	localparam int unsigned DRAIN_WAIT  = 8;
	localparam int unsigned HOLD_AT     = 190;

	// codes the block has no use for
	localparam logic [REQ_W-1:0] REQ_SPARE_6 = 3'd6;
	localparam logic [REQ_W-1:0] REQ_SPARE_7 = 3'd7;

	// one row of the directed table; flat rows give a whole frame of one color
	typedef struct {
		frame_req_t  item;
		bit          flat;
		logic [1:0]  flat_color;
	} dir_row_t;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	frame_req_t req;
	scan_beat_t beat;
	logic       strobe;

	logic [PIX_W-1:0] frame_img [NUM_COLS][NUM_ROWS];
	scan_beat_t       beats_due [$];
	int unsigned      fail_count;
	int unsigned      cycle_count;

	led_matrix_frame_scroll_scan_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.beat   (beat),
		.strobe (strobe)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #(CLK_HALF) clk = ~clk;
	end

	// run watchdog
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic frame_req_t mk_req(logic [REQ_W-1:0] code, logic [COL_W-1:0] col,
			logic [ROW_W-1:0] rw, logic [PIX_W-1:0] clr, logic wr);
		frame_req_t r;
		r.req_type = code;
		r.column   = col;
		r.row      = rw;
		r.color    = clr;
		r.wrap     = wr;
		return r;
	endfunction

	// update the frame image for one accepted request, queue refresh beats
	task automatic apply_req(frame_req_t item, bit flat, logic [1:0] flat_color);
		logic [PIX_W-1:0] keep [NUM_ROWS];
		logic [PIX_W-1:0] top_pix;
		logic [PIX_W-1:0] bot_pix;
		logic [PIX_W-1:0] held;
		scan_beat_t       b;
		int               col;
		int               n;
		n = 0;
		case (item.req_type)
			REQ_WRITE: begin
				frame_img[item.column][item.row] = item.color;
			end
			REQ_FILL: begin
				foreach (frame_img[x, y]) frame_img[x][y] = item.color;
			end
			REQ_LEFT: begin
				for (int y = 0; y < NUM_ROWS; y++) keep[y] = frame_img[0][y];
				for (int x = 0; x < NUM_COLS - 1; x++)
					for (int y = 0; y < NUM_ROWS; y++) frame_img[x][y] = frame_img[x+1][y];
				for (int y = 0; y < NUM_ROWS; y++)
					frame_img[NUM_COLS-1][y] = item.wrap ? keep[y] : '0;
			end
			REQ_RIGHT: begin
				for (int y = 0; y < NUM_ROWS; y++) keep[y] = frame_img[NUM_COLS-1][y];
				for (int x = NUM_COLS - 1; x > 0; x--)
					for (int y = 0; y < NUM_ROWS; y++) frame_img[x][y] = frame_img[x-1][y];
				for (int y = 0; y < NUM_ROWS; y++)
					frame_img[0][y] = item.wrap ? keep[y] : '0;
			end
			REQ_UP: begin
				for (int x = 0; x < NUM_COLS; x++) begin
					held = frame_img[x][0];
					for (int y = 0; y < NUM_ROWS - 1; y++) frame_img[x][y] = frame_img[x][y+1];
					frame_img[x][NUM_ROWS-1] = item.wrap ? held : '0;
				end
			end
			REQ_REFRESH: begin
				// block, row and column within block all count down
				for (int blk = 4; blk >= 1; blk--)
					for (int h = 3; h >= 0; h--)
						for (int w = 3; w >= 0; w--) begin
							col = blk * 4 - 4 + w;
							top_pix = flat ? flat_color : frame_img[col][h];
							bot_pix = flat ? flat_color : frame_img[col][h+4];
							n++;
							b.red_top      = top_pix[0];
							b.green_top    = top_pix[1];
							b.red_bottom   = bot_pix[0];
							b.green_bottom = bot_pix[1];
							b.latch_after  = (n == BEATS);
							beats_due.push_back(b);
						end
			end
			default: begin
				// unused codes change nothing
			end
		endcase
	endtask

	// random request; all field bits random, the code weighted
	function automatic frame_req_t rand_req();
		frame_req_t  r;
		int unsigned pick;
		r = frame_req_t'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 24)      r.req_type = REQ_REFRESH;
		else if (pick < 54) r.req_type = REQ_WRITE;
		else if (pick < 62) r.req_type = REQ_FILL;
		else if (pick < 72) r.req_type = REQ_LEFT;
		else if (pick < 82) r.req_type = REQ_RIGHT;
		else if (pick < 94) r.req_type = REQ_UP;
		else                r.req_type = $urandom_range(0, 1) ? REQ_SPARE_6 : REQ_SPARE_7;
		return r;
	endfunction

	// mostly short gaps, a few long ones
	function automatic int unsigned pick_gap();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 55) return 0;
		if (pick < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 70);
	endfunction

	// drive one request, wait for it to be taken, then idle for the gap
	task automatic send_req(frame_req_t item, int unsigned gap, bit flat,
			logic [1:0] flat_color);
		start <= 1'b1;
		req   <= item;
		do @(posedge clk); while (busy);
		apply_req(item, flat, flat_color);
		if (gap > 0) begin
			start <= 1'b0;
			req   <= frame_req_t'($urandom);
			repeat (gap) @(posedge clk);
		end
	endtask

	// hold off until every predicted beat has come out
	task automatic hold_until_drained();
		start <= 1'b0;
		do @(posedge clk); while (beats_due.size() != 0);
	endtask

	function automatic void check_bit(string field, logic exp_v, logic act_v);
		if (act_v !== exp_v) begin
			$error("beat field %s: expected %0b, got %0b", field, exp_v, act_v);
			fail_count++;
		end
	endfunction

	// beat checker
	always @(posedge clk) begin
		scan_beat_t exp_b;
		if (arst_n && strobe) begin
			if (beats_due.size() == 0) begin
				$error("beat strobed with none expected");
				fail_count++;
			end else begin
				exp_b = beats_due.pop_front();
				check_bit("red_top", exp_b.red_top, beat.red_top);
				check_bit("green_top", exp_b.green_top, beat.green_top);
				check_bit("red_bottom", exp_b.red_bottom, beat.red_bottom);
				check_bit("green_bottom", exp_b.green_bottom, beat.green_bottom);
				check_bit("latch_after", exp_b.latch_after, beat.latch_after);
			end
		end
	end

	// stimulus
	initial begin
		dir_row_t    dir_table [DIR_ROWS];
		frame_req_t  item;
		int unsigned counted;
		int unsigned burst_left;
		int unsigned gap;

		arst_n     = 1'b0;
		start      = 1'b0;
		req        = '0;
		fail_count = 0;
		counted    = 0;
		burst_left = 0;
		foreach (frame_img[x, y]) frame_img[x][y] = '0;

		dir_table = '{
			'{mk_req(REQ_REFRESH, 4'd0, 3'd0, 2'd0, 1'b0), 1'b1, 2'd0},
			'{mk_req(REQ_FILL, 4'd0, 3'd0, 2'd3, 1'b0), 1'b0, 2'd0},
			'{mk_req(REQ_REFRESH, 4'd15, 3'd7, 2'd0, 1'b1), 1'b1, 2'd3},
			'{mk_req(REQ_FILL, 4'd15, 3'd7, 2'd1, 1'b1), 1'b0, 2'd0},
			'{mk_req(REQ_REFRESH, 4'd0, 3'd0, 2'd3, 1'b0), 1'b1, 2'd1},
			'{mk_req(REQ_FILL, 4'd0, 3'd0, 2'd2, 1'b0), 1'b0, 2'd0},
			'{mk_req(REQ_REFRESH, 4'd0, 3'd0, 2'd0, 1'b0), 1'b1, 2'd2},
			'{mk_req(REQ_FILL, 4'd0, 3'd0, 2'd0, 1'b0), 1'b0, 2'd0},
			// corner pixels
			'{mk_req(REQ_WRITE, 4'd0, 3'd0, 2'd3, 1'b0), 1'b0, 2'd0},
			'{mk_req(REQ_WRITE, 4'd15, 3'd7, 2'd1, 1'b1), 1'b0, 2'd0},
			'{mk_req(REQ_WRITE, 4'd15, 3'd0, 2'd2, 1'b0), 1'b0, 2'd0},
			'{mk_req(REQ_WRITE, 4'd0, 3'd7, 2'd3, 1'b1), 1'b0, 2'd0},
			'{mk_req(REQ_REFRESH, 4'd0, 3'd0, 2'd0, 1'b0), 1'b0, 2'd0},
			// scrolls, rotating and filling black
			'{mk_req(REQ_LEFT, 4'd0, 3'd0, 2'd0, 1'b1), 1'b0, 2'd0},
			'{mk_req(REQ_REFRESH, 4'd0, 3'd0, 2'd0, 1'b0), 1'b0, 2'd0},
			'{mk_req(REQ_RIGHT, 4'd0, 3'd0, 2'd0, 1'b1), 1'b0, 2'd0},
			'{mk_req(REQ_RIGHT, 4'd0, 3'd0, 2'd0, 1'b0), 1'b0, 2'd0},
			'{mk_req(REQ_REFRESH, 4'd0, 3'd0, 2'd0, 1'b0), 1'b0, 2'd0},
			'{mk_req(REQ_LEFT, 4'd0, 3'd0, 2'd0, 1'b0), 1'b0, 2'd0},
			'{mk_req(REQ_UP, 4'd0, 3'd0, 2'd0, 1'b1), 1'b0, 2'd0},
			'{mk_req(REQ_REFRESH, 4'd0, 3'd0, 2'd0, 1'b0), 1'b0, 2'd0},
			'{mk_req(REQ_UP, 4'd0, 3'd0, 2'd0, 1'b0), 1'b0, 2'd0},
			// unused codes must leave the frame alone
			'{mk_req(REQ_SPARE_6, 4'd3, 3'd2, 2'd3, 1'b1), 1'b0, 2'd0},
			'{mk_req(REQ_SPARE_7, 4'd12, 3'd5, 2'd1, 1'b0), 1'b0, 2'd0},
			'{mk_req(REQ_REFRESH, 4'd0, 3'd0, 2'd0, 1'b0), 1'b0, 2'd0}
		};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed table
		foreach (dir_table[i])
			send_req(dir_table[i].item, pick_gap(), dir_table[i].flat, dir_table[i].flat_color);

		// random requests; bursts with no idling now and then
		while (counted < RAND_ITEMS) begin
			item = rand_req();
			if (burst_left == 0 && $urandom_range(0, 49) == 0) burst_left = 20;
			if (burst_left > 0) begin
				gap = 0;
				burst_left--;
			end else begin
				gap = pick_gap();
			end
			send_req(item, gap, 1'b0, 2'd0);
			counted++;
			if (counted == HOLD_AT) hold_until_drained();
		end

		// drain and report
		hold_until_drained();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (fail_count == 0 && beats_due.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
